// ===== hw/rtl/merge_sorter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Merge sorter assertion macros
// Shared concurrent assertion forms for the merge sorter RTL.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_TOP_DEFINES_SVH
`define MERGE_SORTER_TOP_DEFINES_SVH

// condition holds on every clock edge outside reset
`define MS_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("merge sorter: invariant violated");

// consequent holds in the same cycle as the antecedent
`define MS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("merge sorter: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define MS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("merge sorter: next-cycle check failed");

`endif

// ===== hw/rtl/msort_pkg.sv =====
// ----------------------------------------------------------------------------
// Merge sorter package
// Defaults and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msort_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int DATA_W        = 32;

   // controller to datapath
   typedef struct packed {
      logic load;        // store one input value
      logic run_setup;   // open the next run pair of the pass
      logic merge_wr;    // write one merged element
      logic emit_init;   // rewind for emission
      logic emit_wr;     // present one sorted element
   } ms_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sort_done;   // run width covers the whole set
      logic at_end;      // current element is the last of the set
      logic run_end;     // current element is the last of the run pair
   } ms_sts_type;

endpackage

// ===== hw/rtl/msort_ctrl.sv =====
// ----------------------------------------------------------------------------
// Merge sorter controller
// Sequences loading, the bottom-up merge passes and the emission of results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msort_ctrl import msort_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_is_last,
   input  ms_sts_type sts,
   output logic       busy,
   output ms_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_SORT_CHECK = 3'd1;
   localparam logic [2:0] ST_RUN_SETUP  = 3'd2;
   localparam logic [2:0] ST_MERGE_RD   = 3'd3;
   localparam logic [2:0] ST_MERGE_WR   = 3'd4;
   localparam logic [2:0] ST_EMIT_RD    = 3'd5;
   localparam logic [2:0] ST_EMIT_WR    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start && req_is_last) begin
               state_in = ST_SORT_CHECK;
            end
         end
         ST_SORT_CHECK: begin
            if (sts.sort_done) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end else begin
               state_in = ST_RUN_SETUP;
            end
         end
         ST_RUN_SETUP: begin
            cmd.run_setup = 1'b1;
            state_in      = ST_MERGE_RD;
         end
         ST_MERGE_RD: begin
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            cmd.merge_wr = 1'b1;
            if (sts.at_end) begin
               state_in = ST_SORT_CHECK;
            end else if (sts.run_end) begin
               state_in = ST_RUN_SETUP;
            end else begin
               state_in = ST_MERGE_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            cmd.emit_wr = 1'b1;
            state_in    = sts.at_end ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/msort_datapath.sv =====
// ----------------------------------------------------------------------------
// Merge sorter datapath
// Two ping-pong buffers, merge pointers, run bounds and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "merge_sorter_top_defines.svh"

module msort_datapath import msort_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ms_cmd_type               cmd,
   output ms_sts_type               sts,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_last_out,
   output logic                     rsp_overflow
);

   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int WID_W  = CNT_W + 1;
   localparam int SUM_W  = CNT_W + 2;

   logic signed [DATA_W-1:0] buf0_mem [MAX_ITEMS];
   logic signed [DATA_W-1:0] buf1_mem [MAX_ITEMS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [WID_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic             src_ff, src_in;
   logic             out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic             out_last_ff, out_last_in;
   logic             out_ovf_ff, out_ovf_in;

   logic signed [DATA_W-1:0] b0_i_ff, b0_j_ff, b1_i_ff, b1_j_ff;
   logic signed [DATA_W-1:0] rd_i, rd_j, merge_data, wr_data;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr0, wr1, full, take_i;
   logic [CNT_W-1:0]  k_inc, run_mid, run_hi;
   logic [SUM_W-1:0]  sum_mid, sum_hi, n_ext;

   assign full  = (count_ff == CNT_W'(MAX_ITEMS));
   assign rd_i  = src_ff ? b1_i_ff : b0_i_ff;
   assign rd_j  = src_ff ? b1_j_ff : b0_j_ff;
   // left run wins ties to keep the sort stable
   assign take_i = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (rd_i <= rd_j));
   assign merge_data = take_i ? rd_i : rd_j;
   assign k_inc = k_ff + CNT_W'(1);

   assign n_ext   = SUM_W'(count_ff);
   assign sum_mid = SUM_W'(k_ff) + SUM_W'(width_ff);
   assign sum_hi  = sum_mid + SUM_W'(width_ff);
   assign run_mid = (sum_mid > n_ext) ? count_ff : sum_mid[CNT_W-1:0];
   assign run_hi  = (sum_hi > n_ext) ? count_ff : sum_hi[CNT_W-1:0];

   assign sts.sort_done = (width_ff >= WID_W'(count_ff));
   assign sts.at_end    = (k_inc == count_ff);
   assign sts.run_end   = (k_inc == hi_ff);

   assign wr_addr = cmd.load ? count_ff[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
   assign wr_data = cmd.load ? req_value_in : merge_data;
   assign wr0     = (cmd.load && !full) || (cmd.merge_wr && src_ff);
   assign wr1     = cmd.merge_wr && !src_ff;

   always_ff @(posedge clock) begin
      if (wr0) begin
         buf0_mem[wr_addr] <= wr_data;
      end
      b0_i_ff <= buf0_mem[i_ff[ADDR_W-1:0]];
      b0_j_ff <= buf0_mem[j_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr1) begin
         buf1_mem[wr_addr] <= wr_data;
      end
      b1_i_ff <= buf1_mem[i_ff[ADDR_W-1:0]];
      b1_j_ff <= buf1_mem[j_ff[ADDR_W-1:0]];
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      width_in     = width_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      src_in       = src_ff;
      out_valid_in = 1'b0;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (cmd.load) begin
         // drop the item once the buffer is full
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         width_in = WID_W'(1);
         k_in     = '0;
         src_in   = 1'b0;
      end

      if (cmd.run_setup) begin
         i_in   = k_ff;
         j_in   = run_mid;
         mid_in = run_mid;
         hi_in  = run_hi;
      end

      if (cmd.merge_wr) begin
         if (take_i) begin
            i_in = i_ff + CNT_W'(1);
         end else begin
            j_in = j_ff + CNT_W'(1);
         end
         // pass complete: double the run width and swap buffers
         if (sts.at_end) begin
            k_in     = '0;
            width_in = width_ff << 1;
            src_in   = !src_ff;
         end else begin
            k_in = k_inc;
         end
      end

      if (cmd.emit_init) begin
         i_in = '0;
         k_in = '0;
      end

      if (cmd.emit_wr) begin
         out_valid_in = 1'b1;
         out_value_in = rd_i;
         out_last_in  = sts.at_end;
         out_ovf_in   = sts.at_end && ovf_ff;
         i_in         = i_ff + CNT_W'(1);
         k_in         = k_inc;
         if (sts.at_end) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff     <= width_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      src_ff       <= src_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_out     = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

   `MS_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(MAX_ITEMS))
   `MS_ASSERT_NEXT(a_strobe_gap, clock, reset, out_valid_ff, !out_valid_ff)
   `MS_ASSERT_SAME(a_last_clears, clock, reset, out_valid_ff && out_last_ff, (count_ff == '0) && !ovf_ff)
   `MS_ASSERT_SAME(a_ovf_on_last, clock, reset, out_valid_ff && out_ovf_ff, out_last_ff)

endmodule

// ===== hw/rtl/merge_sorter_top.sv =====
// ----------------------------------------------------------------------------
// Merge sorter top level
// Collects up to MAX_ITEMS signed 32-bit values, one per start pulse while
// busy is low, and the item with req_is_last closes the set. The block then
// raises busy, sorts the set ascending with a stable bottom-up merge sort
// (equal values keep their arrival order) and emits each value as a one-cycle
// rsp_valid strobe, each read in EMIT_RD and presented from EMIT_WR; the
// receiver cannot stall, so it must take every strobe. rsp_last_out marks the
// final value, and rsp_overflow on it reports that items beyond MAX_ITEMS
// were dropped. Loading writes each item straight into the first buffer. A
// sort runs ceil(log2 N) merge passes over N values; each pass opens every
// run pair in RUN_SETUP and merges each element with a read state and a
// write state, as each buffer has a single write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module merge_sorter_top import msort_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_value_in,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_last_out,
   output logic                     rsp_overflow
);

   ms_cmd_type cmd;
   ms_sts_type sts;

   msort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_last (req_is_last),
      .sts         (sts),
      .busy        (busy),
      .cmd         (cmd)
   );

   msort_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== test/tb_merge_sorter_top.sv =====
// ----------------------------------------------------------------------------
// Merge sorter testbench
// Feeds sets of signed values through the start/busy port and checks every
// sorted value, last flag and overflow flag against a local sort of the set
// (single-value sets: against their table row). A short table of directed
// sets comes first: single values at the extremes, ties, sorted and reversed
// input. Then random sets, full and past capacity, the closing item dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_merge_sorter_top import msort_pkg::*;;

   localparam int MAX_ITEMS    = MAX_ITEMS_DEF;
   localparam int ITEM_TARGET  = 430;
   localparam int CALM_FROM    = 380;
   localparam int DRAIN_CYCLES = 60;
   localparam int DIR_ROWS     = 24;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     ovf;
   } sorted_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     is_last;
      logic                     typed;
      sorted_item_type          want;
   } stim_row_type;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_value_in;
   logic                     req_is_last;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_last_out;
   logic                     rsp_overflow;

   // local copy of the set being collected
   logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
   logic signed [DATA_W-1:0] scratch   [MAX_ITEMS];
   int                       held_count;
   logic                     held_ovf;

   sorted_item_type pending_sorted [$];
   sorted_item_type fresh_results  [$];
   int              error_count;
   int              items_sent;

   stim_row_type dir_rows [DIR_ROWS] = '{
      // single-value sets, result readable at a glance
      '{VAL_MAX, 1'b1, 1'b1, '{VAL_MAX, 1'b1, 1'b0}},
      '{VAL_MIN, 1'b1, 1'b1, '{VAL_MIN, 1'b1, 1'b0}},
      '{32'sd0,  1'b1, 1'b1, '{32'sd0,  1'b1, 1'b0}},
      '{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
      // both extremes, reversed
      '{VAL_MAX, 1'b0, 1'b0, '0},
      '{VAL_MIN, 1'b1, 1'b0, '0},
      // ties and mixed signs
      '{32'sd3,  1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{32'sd3,  1'b0, 1'b0, '0},
      '{32'sd0,  1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{VAL_MIN, 1'b0, 1'b0, '0},
      '{VAL_MAX, 1'b0, 1'b0, '0},
      '{32'sd1,  1'b1, 1'b0, '0},
      // already ascending
      '{32'sd1,  1'b0, 1'b0, '0},
      '{32'sd2,  1'b0, 1'b0, '0},
      '{32'sd3,  1'b1, 1'b0, '0},
      // descending
      '{32'sd5,  1'b0, 1'b0, '0},
      '{32'sd4,  1'b0, 1'b0, '0},
      '{32'sd3,  1'b0, 1'b0, '0},
      '{32'sd2,  1'b0, 1'b0, '0},
      '{32'sd1,  1'b1, 1'b0, '0},
      // all equal, alternating bits
      '{32'sh5555_5555, 1'b0, 1'b0, '0},
      '{32'sh5555_5555, 1'b1, 1'b0, '0}
   };

   merge_sorter_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value_in     (req_value_in),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // stable bottom-up merge of the held set, left run wins on a tie
   task automatic sort_held(input int n);
      int width, lo, mid, hi, i, j, k;
      for (width = 1; width < n; width *= 2) begin
         for (lo = 0; lo + width < n; lo += 2 * width) begin
            mid = lo + width;
            hi  = (mid + width > n) ? n : mid + width;
            i = lo;
            j = mid;
            k = lo;
            while (i < mid && j < hi) begin
               if (held_vals[i] <= held_vals[j]) begin
                  scratch[k] = held_vals[i];
                  i++;
               end else begin
                  scratch[k] = held_vals[j];
                  j++;
               end
               k++;
            end
            while (i < mid) begin
               scratch[k] = held_vals[i];
               i++;
               k++;
            end
            while (j < hi) begin
               scratch[k] = held_vals[j];
               j++;
               k++;
            end
            for (k = lo; k < hi; k++)
               held_vals[k] = scratch[k];
         end
      end
   endtask

   // store or drop one value; on the closing item, produce the sorted set
   task automatic absorb_item(input logic signed [DATA_W-1:0] v, input logic lst);
      sorted_item_type item;
      int              k;
      fresh_results.delete();
      if (held_count < MAX_ITEMS) begin
         held_vals[held_count] = v;
         held_count++;
      end else begin
         held_ovf = 1'b1;
      end
      if (lst) begin
         sort_held(held_count);
         for (k = 0; k < held_count; k++) begin
            item.value = held_vals[k];
            item.last  = (k == held_count - 1);
            item.ovf   = item.last ? held_ovf : 1'b0;
            fresh_results.push_back(item);
         end
         held_count = 0;
         held_ovf   = 1'b0;
      end
   endtask

   // hold the item until the block takes it; start stays high afterwards
   task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst,
                            input logic typed, input sorted_item_type want);
      @(negedge clock);
      start        = 1'b1;
      req_value_in = v;
      req_is_last  = lst;
      do @(posedge clock); while (busy);
      absorb_item(v, lst);
      if (typed) begin
         if (lst)
            pending_sorted.push_back(want);
      end else begin
         foreach (fresh_results[k])
            pending_sorted.push_back(fresh_results[k]);
      end
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic wait_sorted_drained();
      pause_sender(1);
      while (pending_sorted.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      unique case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
         1, 2, 3: return $signed($urandom_range(0, 8)) - 32'sd4;
         default: return $signed($urandom);
      endcase
   endfunction

   always @(posedge clock) begin : check_results
      sorted_item_type head;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_sorted.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_sorted_value));
         end else begin
            head = pending_sorted.pop_front();
            if (rsp_sorted_value !== head.value)
               report_mismatch($sformatf("value %0d, want %0d",
                                         rsp_sorted_value, head.value));
            if (rsp_last_out !== head.last)
               report_mismatch($sformatf("last flag %b, want %b",
                                         rsp_last_out, head.last));
            if (rsp_overflow !== head.ovf)
               report_mismatch($sformatf("overflow flag %b, want %b",
                                         rsp_overflow, head.ovf));
         end
      end
   end

   initial begin : stimulus
      int              set_idx;
      int              set_size;
      int              n;
      logic            idle_on;
      sorted_item_type none;
      none         = '0;
      reset        = 1'b1;
      start        = 1'b0;
      req_value_in = '0;
      req_is_last  = 1'b0;
      held_count   = 0;
      held_ovf     = 1'b0;
      error_count  = 0;
      items_sent   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[r])
         send_item(dir_rows[r].value, dir_rows[r].is_last, dir_rows[r].typed,
                   dir_rows[r].want);
      wait_sorted_drained();

      set_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         // force a full set and two past capacity early on
         unique case (set_idx)
            1:       set_size = MAX_ITEMS;
            3:       set_size = MAX_ITEMS + 3;
            5:       set_size = MAX_ITEMS + 1;
            default: set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70)
                                                            : $urandom_range(1, 12);
         endcase
         idle_on = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
         for (n = 0; n < set_size; n++) begin
            if (idle_on && $urandom_range(0, 2) == 0)
               pause_sender($urandom_range(1, 16));
            send_item(pick_value(), n == set_size - 1, 1'b0, none);
         end
         if (set_idx == 2 || (items_sent < CALM_FROM && $urandom_range(0, 7) == 0))
            wait_sorted_drained();
         set_idx++;
      end

      wait_sorted_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_sorted.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_sorted.size()));
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/msort_pkg.sv
hw/rtl/msort_ctrl.sv
hw/rtl/msort_datapath.sv
hw/rtl/merge_sorter_top.sv
test/tb_merge_sorter_top.sv
